FILE: rtl/core/ffca_pkg.sv
package ffca_pkg;

    localparam int ARENA_BYTES    = 8388608;
    localparam int ALIGN          = 16;        // power of two
    localparam int FREE_ENTRIES   = 64;
    localparam int ACTIVE_ENTRIES = 64;
    localparam int RING_DEPTH     = 32;
    localparam int GUARD_RESET    = 4;

    localparam int AW = 23;                    // arena offset
    localparam int SW = 24;                    // size, length, 24-bit offset
    localparam int PW = 48;                    // array product
    localparam int FW = 25;                    // footprint before clipping
    localparam int GW = 7;                     // guard register

    localparam int FAW = (FREE_ENTRIES > 1) ? $clog2(FREE_ENTRIES) : 1;
    localparam int AAW = (ACTIVE_ENTRIES > 1) ? $clog2(ACTIVE_ENTRIES) : 1;
    localparam int RAW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam int FCW = $clog2(FREE_ENTRIES + 1);
    localparam int ACW = $clog2(ACTIVE_ENTRIES + 1);
    localparam int RFW = $clog2(RING_DEPTH + 1);
    localparam int IW0 = (FCW > ACW) ? FCW : ACW;
    localparam int IW  = (IW0 > RFW) ? IW0 : RFW;

    localparam logic [1:0] OP_ALLOC = 2'd0;
    localparam logic [1:0] OP_FREE  = 2'd1;
    localparam logic [1:0] OP_ARRAY = 2'd2;

    typedef enum logic [2:0] {
        ST_OK,
        ST_OOM,
        ST_NULL,
        ST_NOTALLOC,
        ST_NOTHEAP,
        ST_DOUBLE,
        ST_FULL
    } status_t;

    typedef enum logic [5:0] {
        CMD_NONE,
        CMD_LOAD,
        CMD_MUL,
        CMD_FOOT,
        CMD_BUMP,
        CMD_FAIL_OOM,
        CMD_FAIL_FULL,
        CMD_ST_NULL,
        CMD_ST_DOUBLE,
        CMD_ST_NOTHEAP,
        CMD_ST_NOTALLOC,
        CMD_ST_FULL,
        CMD_INC,
        CMD_I0,
        CMD_FRD_I,
        CMD_FRD_I1,
        CMD_FRD_IM1,
        CMD_TAKE_EXACT,
        CMD_TAKE_SPLIT,
        CMD_FWR_I_RD,
        CMD_FWR_I_DEC,
        CMD_FDEC,
        CMD_COMMIT,
        CMD_OUT,
        CMD_ARD_I,
        CMD_KEEP_K,
        CMD_CLIP,
        CMD_P_END,
        CMD_P_HIT,
        CMD_PREV,
        CMD_BUMP_DOWN_F,
        CMD_BUMP_DOWN_M,
        CMD_I_FCNT,
        CMD_INS_P,
        CMD_MERGE_BOTH,
        CMD_MERGE_PREV,
        CMD_MERGE_NEXT,
        CMD_ARD_LAST,
        CMD_FREE_DONE,
        CMD_RRD_I,
        CMD_SET_OFF
    } cmd_t;

    typedef struct packed {
        logic [AW-1:0] start;
        logic [SW-1:0] len;
    } entry_t;

    typedef struct packed {
        logic [1:0] op;
        logic       present;
        logic       bad_array;
        logic       act_full;
        logic       size_big;
        logic       bump_fit;
        logic       i_lt_fcnt;
        logic       i1_lt_fcnt;
        logic       i_lt_acnt;
        logic       i_lt_fill;
        logic       i_gt_p;
        logic       hit_len;
        logic       len_eq;
        logic       hit_gt;
        logic       hit_act;
        logic       hit_ring;
        logic       hit_contain;
        logic       addr_out;
        logic       pm;
        logic       nm;
        logic       e_is_bump;
        logic       free_full;
        logic       top_hit;
        logic       out_free;
    } dp_flags_t;

endpackage

FILE: rtl/core/ffca_ram.sv
module ffca_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

FILE: rtl/core/ffca_datapath.sv
module ffca_datapath (
    input  logic                clk,
    input  logic                rst_n,
    input  ffca_pkg::cmd_t      cmd,
    output ffca_pkg::dp_flags_t flags,
    input  logic [1:0]          operation,
    input  logic [23:0]         request_size,
    input  logic [23:0]         element_count,
    input  logic [23:0]         address,
    input  logic                pointer_present,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [22:0]         allocated_address,
    output logic [2:0]          status,
    output logic [22:0]         offset_in_region,
    output logic [6:0]          live_allocations,
    output logic [23:0]         live_bytes,
    output logic [31:0]         allocations_made,
    output logic [39:0]         bytes_allocated,
    output logic [31:0]         failures,
    output logic [47:0]         failed_bytes,
    output logic [23:0]         lowest_address,
    output logic [22:0]         highest_address
);
    import ffca_pkg::*;

    logic [GW-1:0]  guard_reg;
    logic [SW-1:0]  bump_reg;
    logic [FCW-1:0] fcnt_reg;
    logic [ACW-1:0] acnt_reg;
    logic [RFW-1:0] rfill_reg;
    logic [RAW-1:0] rhead_reg;
    logic [SW-1:0]  live_reg;
    logic [31:0]    acount_reg;
    logic [39:0]    abytes_reg;
    logic [31:0]    fcount_reg;
    logic [47:0]    fbytes_reg;
    logic [SW-1:0]  low_reg;
    logic [AW-1:0]  high_reg;
    logic           out_valid_reg;

    logic [1:0]     op_reg;
    logic [SW-1:0]  rsz_reg;
    logic [SW-1:0]  cnt_reg;
    logic [SW-1:0]  addr_reg;
    logic           present_reg;
    logic [PW-1:0]  size_reg;
    logic [FW-1:0]  f_reg;
    logic [AW-1:0]  a_reg;
    status_t        st_reg;
    logic [AW-1:0]  off_reg;
    logic [IW-1:0]  i_reg;
    logic [AAW-1:0] k_reg;
    logic [FCW-1:0] p_reg;
    logic [FAW-1:0] slot_reg;
    logic [AW-1:0]  s_reg;
    entry_t         prev_reg;
    entry_t         cur_reg;
    entry_t         merged_reg;

    logic [22:0]    out_addr_reg;
    logic [2:0]     out_status_reg;
    logic [22:0]    out_off_reg;
    logic [6:0]     out_live_alloc_reg;
    logic [23:0]    out_live_bytes_reg;
    logic [31:0]    out_acount_reg;
    logic [39:0]    out_abytes_reg;
    logic [31:0]    out_fcount_reg;
    logic [47:0]    out_fbytes_reg;
    logic [23:0]    out_low_reg;
    logic [22:0]    out_high_reg;

    entry_t         frd;
    entry_t         ard;
    logic [SW-1:0]  rrd;

    logic           f_we, f_re, a_we, a_re, r_we, r_re;
    logic [FAW-1:0] f_waddr, f_raddr;
    logic [AAW-1:0] a_waddr, a_raddr;
    logic [RAW-1:0] r_raddr;
    entry_t         f_wdata, a_wdata;

    logic [IW:0]    i_inc;
    logic [IW-1:0]  i_dec;
    logic [ACW-1:0] acnt_dec;
    logic [FCW-1:0] p_dec;
    logic [FW-1:0]  foot_sum, foot_rnd, foot_val, bump_room;
    logic [SW-1:0]  clip_room, e_val, last_val;
    entry_t         merged_val;
    logic [FAW-1:0] slot_val;
    logic [SW:0]    live_add;
    logic [40:0]    abytes_add;
    logic [48:0]    fbytes_add;
    logic [SW-1:0]  sz24;
    logic           cfg_write;

    assign sz24      = size_reg[SW-1:0];
    assign i_inc     = {1'b0, i_reg} + 1'b1;
    assign i_dec     = i_reg - 1'b1;
    assign acnt_dec  = acnt_reg - 1'b1;
    assign p_dec     = p_reg - 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign prdata    = {{(32-GW){1'b0}}, guard_reg};

    // footprint: size plus guard, rounded up, never zero
    assign foot_sum  = FW'(sz24) + FW'(guard_reg) + FW'(ALIGN - 1);
    assign foot_rnd  = foot_sum & ~FW'(ALIGN - 1);
    assign foot_val  = (foot_rnd == '0) ? FW'(ALIGN) : foot_rnd;
    assign bump_room = FW'(ARENA_BYTES) - FW'(bump_reg);
    assign clip_room = SW'(ARENA_BYTES) - SW'(s_reg);
    assign e_val     = SW'(s_reg) + f_reg[SW-1:0];
    assign last_val  = (sz24 != '0) ? (SW'(a_reg) + sz24 - 1'b1) : SW'(a_reg);

    assign live_add   = {1'b0, live_reg} + {1'b0, sz24};
    assign abytes_add = {1'b0, abytes_reg} + 41'(sz24);
    assign fbytes_add = {1'b0, fbytes_reg} + {1'b0, size_reg};

    always_comb
    begin
        case (cmd)
            CMD_MERGE_BOTH:
            begin
                merged_val.start = prev_reg.start;
                merged_val.len   = SW'(cur_reg.start) + cur_reg.len - SW'(prev_reg.start);
                slot_val         = p_dec[FAW-1:0];
            end
            CMD_MERGE_PREV:
            begin
                merged_val.start = prev_reg.start;
                merged_val.len   = prev_reg.len + f_reg[SW-1:0];
                slot_val         = p_dec[FAW-1:0];
            end
            default:
            begin
                merged_val.start = s_reg;
                merged_val.len   = cur_reg.len + f_reg[SW-1:0];
                slot_val         = p_reg[FAW-1:0];
            end
        endcase
    end

    // table port control
    always_comb
    begin
        f_we    = 1'b0;
        f_waddr = i_reg[FAW-1:0];
        f_wdata = frd;
        f_re    = 1'b0;
        f_raddr = i_reg[FAW-1:0];
        a_we    = 1'b0;
        a_waddr = k_reg;
        a_wdata = ard;
        a_re    = 1'b0;
        a_raddr = i_reg[AAW-1:0];
        r_we    = 1'b0;
        r_re    = 1'b0;
        r_raddr = i_reg[RAW-1:0];
        case (cmd)
            CMD_FRD_I:
            begin
                f_re = 1'b1;
            end
            CMD_FRD_I1:
            begin
                f_re    = 1'b1;
                f_raddr = i_inc[FAW-1:0];
            end
            CMD_FRD_IM1:
            begin
                f_re    = 1'b1;
                f_raddr = i_dec[FAW-1:0];
            end
            CMD_TAKE_SPLIT:
            begin
                f_we          = 1'b1;
                f_wdata.start = frd.start + f_reg[AW-1:0];
                f_wdata.len   = frd.len - f_reg[SW-1:0];
            end
            CMD_FWR_I_RD, CMD_FWR_I_DEC:
            begin
                f_we = 1'b1;
            end
            CMD_INS_P:
            begin
                f_we          = 1'b1;
                f_waddr       = p_reg[FAW-1:0];
                f_wdata.start = s_reg;
                f_wdata.len   = f_reg[SW-1:0];
            end
            CMD_MERGE_BOTH, CMD_MERGE_PREV, CMD_MERGE_NEXT:
            begin
                f_we    = 1'b1;
                f_waddr = slot_val;
                f_wdata = merged_val;
            end
            CMD_ARD_I:
            begin
                a_re = 1'b1;
            end
            CMD_ARD_LAST:
            begin
                a_re    = 1'b1;
                a_raddr = acnt_dec[AAW-1:0];
            end
            CMD_COMMIT:
            begin
                a_we          = 1'b1;
                a_waddr       = acnt_reg[AAW-1:0];
                a_wdata.start = a_reg;
                a_wdata.len   = sz24;
            end
            CMD_FREE_DONE:
            begin
                a_we = 1'b1;
                r_we = 1'b1;
            end
            CMD_RRD_I:
            begin
                r_re = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    ffca_ram #(.WIDTH($bits(entry_t)), .DEPTH(FREE_ENTRIES)) u_free_ram (
        .clk   (clk),
        .we    (f_we),
        .waddr (f_waddr),
        .wdata (f_wdata),
        .re    (f_re),
        .raddr (f_raddr),
        .rdata (frd)
    );

    ffca_ram #(.WIDTH($bits(entry_t)), .DEPTH(ACTIVE_ENTRIES)) u_active_ram (
        .clk   (clk),
        .we    (a_we),
        .waddr (a_waddr),
        .wdata (a_wdata),
        .re    (a_re),
        .raddr (a_raddr),
        .rdata (ard)
    );

    ffca_ram #(.WIDTH(SW), .DEPTH(RING_DEPTH)) u_ring_ram (
        .clk   (clk),
        .we    (r_we),
        .waddr (rhead_reg),
        .wdata (addr_reg),
        .re    (r_re),
        .raddr (r_raddr),
        .rdata (rrd)
    );

    always_comb
    begin
        flags.op          = op_reg;
        flags.present     = present_reg;
        flags.bad_array   = (cnt_reg == '0) || (rsz_reg == '0)
                            || (cnt_reg > SW'(ARENA_BYTES)) || (rsz_reg > SW'(ARENA_BYTES));
        flags.act_full    = acnt_reg >= ACW'(ACTIVE_ENTRIES);
        flags.size_big    = size_reg > PW'(ARENA_BYTES);
        flags.bump_fit    = f_reg <= bump_room;
        flags.i_lt_fcnt   = i_reg < IW'(fcnt_reg);
        flags.i1_lt_fcnt  = i_inc < (IW + 1)'(fcnt_reg);
        flags.i_lt_acnt   = i_reg < IW'(acnt_reg);
        flags.i_lt_fill   = i_reg < IW'(rfill_reg);
        flags.i_gt_p      = i_reg > IW'(p_reg);
        flags.hit_len     = FW'(frd.len) >= f_reg;
        flags.len_eq      = FW'(frd.len) == f_reg;
        flags.hit_gt      = frd.start > s_reg;
        flags.hit_act     = SW'(ard.start) == addr_reg;
        flags.hit_ring    = rrd == addr_reg;
        flags.hit_contain = (SW'(ard.start) < addr_reg)
                            && ((addr_reg - SW'(ard.start)) < ard.len);
        flags.addr_out    = addr_reg >= SW'(ARENA_BYTES);
        flags.pm          = (p_reg != '0)
                            && ((SW'(prev_reg.start) + prev_reg.len) == SW'(s_reg));
        flags.nm          = (p_reg < fcnt_reg) && (SW'(cur_reg.start) == e_val);
        flags.e_is_bump   = e_val == bump_reg;
        flags.free_full   = fcnt_reg >= FCW'(FREE_ENTRIES);
        flags.top_hit     = (SW'(merged_reg.start) + merged_reg.len) == bump_reg;
        flags.out_free    = !out_valid_reg || !out_stall;
    end

    // arena state, statistics and output handshake
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            guard_reg     <= GW'(GUARD_RESET);
            bump_reg      <= '0;
            fcnt_reg      <= '0;
            acnt_reg      <= '0;
            rfill_reg     <= '0;
            rhead_reg     <= '0;
            live_reg      <= '0;
            acount_reg    <= '0;
            abytes_reg    <= '0;
            fcount_reg    <= '0;
            fbytes_reg    <= '0;
            low_reg       <= '1;
            high_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                guard_reg <= pwdata[GW-1:0];
            end
            if (cmd == CMD_OUT)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            case (cmd)
                CMD_BUMP:
                begin
                    bump_reg <= bump_reg + f_reg[SW-1:0];
                end
                CMD_FAIL_OOM, CMD_FAIL_FULL:
                begin
                    if (fcount_reg != '1)
                    begin
                        fcount_reg <= fcount_reg + 1'b1;
                    end
                    fbytes_reg <= fbytes_add[48] ? '1 : fbytes_add[47:0];
                end
                CMD_FDEC:
                begin
                    fcnt_reg <= fcnt_reg - 1'b1;
                end
                CMD_INS_P:
                begin
                    fcnt_reg <= fcnt_reg + 1'b1;
                end
                CMD_BUMP_DOWN_F:
                begin
                    bump_reg <= bump_reg - f_reg[SW-1:0];
                end
                CMD_BUMP_DOWN_M:
                begin
                    bump_reg <= bump_reg - merged_reg.len;
                end
                CMD_COMMIT:
                begin
                    acnt_reg   <= acnt_reg + 1'b1;
                    live_reg   <= live_add[SW] ? '1 : live_add[SW-1:0];
                    abytes_reg <= abytes_add[40] ? '1 : abytes_add[39:0];
                    if (acount_reg != '1)
                    begin
                        acount_reg <= acount_reg + 1'b1;
                    end
                    if (SW'(a_reg) < low_reg)
                    begin
                        low_reg <= SW'(a_reg);
                    end
                    if (last_val > SW'(high_reg))
                    begin
                        high_reg <= last_val[AW-1:0];
                    end
                end
                CMD_ARD_LAST:
                begin
                    acnt_reg <= acnt_dec;
                end
                CMD_FREE_DONE:
                begin
                    live_reg  <= (live_reg > sz24) ? (live_reg - sz24) : '0;
                    rhead_reg <= (rhead_reg == RAW'(RING_DEPTH - 1)) ? '0 : rhead_reg + 1'b1;
                    if (rfill_reg < RFW'(RING_DEPTH))
                    begin
                        rfill_reg <= rfill_reg + 1'b1;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // per-request working registers
    always_ff @(posedge clk)
    begin
        case (cmd)
            CMD_LOAD:
            begin
                op_reg      <= operation;
                rsz_reg     <= request_size;
                cnt_reg     <= element_count;
                addr_reg    <= address;
                present_reg <= pointer_present;
                size_reg    <= PW'(request_size);
                st_reg      <= ST_OK;
                a_reg       <= '0;
                off_reg     <= '0;
                i_reg       <= '0;
            end
            CMD_MUL:
            begin
                size_reg <= PW'(cnt_reg) * PW'(rsz_reg);
            end
            CMD_FOOT:
            begin
                f_reg <= foot_val;
                i_reg <= '0;
            end
            CMD_BUMP:
            begin
                a_reg <= bump_reg[AW-1:0];
            end
            CMD_FAIL_OOM:
            begin
                st_reg <= ST_OOM;
            end
            CMD_FAIL_FULL, CMD_ST_FULL:
            begin
                st_reg <= ST_FULL;
            end
            CMD_ST_NULL:
            begin
                st_reg <= ST_NULL;
            end
            CMD_ST_DOUBLE:
            begin
                st_reg <= ST_DOUBLE;
            end
            CMD_ST_NOTHEAP:
            begin
                st_reg <= ST_NOTHEAP;
            end
            CMD_ST_NOTALLOC:
            begin
                st_reg <= ST_NOTALLOC;
            end
            CMD_INC, CMD_FWR_I_RD:
            begin
                i_reg <= i_inc[IW-1:0];
            end
            CMD_FWR_I_DEC:
            begin
                i_reg <= i_dec;
            end
            CMD_I0:
            begin
                i_reg <= '0;
            end
            CMD_TAKE_EXACT, CMD_TAKE_SPLIT:
            begin
                a_reg <= frd.start;
            end
            CMD_KEEP_K:
            begin
                k_reg    <= i_reg[AAW-1:0];
                s_reg    <= ard.start;
                size_reg <= PW'(ard.len);
            end
            CMD_CLIP:
            begin
                if (f_reg > FW'(clip_room))
                begin
                    f_reg <= FW'(clip_room);
                end
            end
            CMD_P_END:
            begin
                p_reg <= fcnt_reg;
            end
            CMD_P_HIT:
            begin
                p_reg   <= i_reg[FCW-1:0];
                cur_reg <= frd;
            end
            CMD_PREV:
            begin
                prev_reg <= frd;
                i_reg    <= i_inc[IW-1:0];
            end
            CMD_I_FCNT:
            begin
                i_reg <= IW'(fcnt_reg);
            end
            CMD_MERGE_BOTH:
            begin
                merged_reg <= merged_val;
                slot_reg   <= slot_val;
                i_reg      <= IW'(p_reg);
            end
            CMD_MERGE_PREV, CMD_MERGE_NEXT:
            begin
                merged_reg <= merged_val;
                slot_reg   <= slot_val;
            end
            CMD_BUMP_DOWN_M:
            begin
                i_reg <= IW'(slot_reg);
            end
            CMD_SET_OFF:
            begin
                off_reg <= addr_reg[AW-1:0] - ard.start;
            end
            CMD_OUT:
            begin
                out_addr_reg       <= a_reg;
                out_status_reg     <= st_reg;
                out_off_reg        <= off_reg;
                out_live_alloc_reg <= 7'(acnt_reg);
                out_live_bytes_reg <= live_reg;
                out_acount_reg     <= acount_reg;
                out_abytes_reg     <= abytes_reg;
                out_fcount_reg     <= fcount_reg;
                out_fbytes_reg     <= fbytes_reg;
                out_low_reg        <= low_reg;
                out_high_reg       <= high_reg;
            end
            default:
            begin
            end
        endcase
    end

    assign out_valid         = out_valid_reg;
    assign allocated_address = out_addr_reg;
    assign status            = out_status_reg;
    assign offset_in_region  = out_off_reg;
    assign live_allocations  = out_live_alloc_reg;
    assign live_bytes        = out_live_bytes_reg;
    assign allocations_made  = out_acount_reg;
    assign bytes_allocated   = out_abytes_reg;
    assign failures          = out_fcount_reg;
    assign failed_bytes      = out_fbytes_reg;
    assign lowest_address    = out_low_reg;
    assign highest_address   = out_high_reg;

endmodule

FILE: rtl/core/ffca_ctrl.sv
module ffca_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  ffca_pkg::dp_flags_t flags,
    output ffca_pkg::cmd_t      cmd
);
    import ffca_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE,
        S_DECODE,
        S_MUL,
        S_MULCHK,
        S_ALLOC,
        S_BUMPCHK,
        S_FS_RD,
        S_FS_CHK,
        S_RM_RD,
        S_RM_WR,
        S_COMMIT,
        S_FINISH,
        S_AF_RD,
        S_AF_CHK,
        S_FF_FOOT,
        S_FF_CLIP,
        S_FP_RD,
        S_FP_CHK,
        S_FP_DEC,
        S_INS_RD,
        S_INS_WR,
        S_TOPCHK,
        S_FR_RD,
        S_FR_WR,
        S_RG_RD,
        S_RG_CHK,
        S_NH_CHK,
        S_CN_RD,
        S_CN_CHK
    } state_t;

    state_t state_reg, state_next;
    state_t ret_reg, ret_next;

    assign in_stall = (state_reg != S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        ret_next   = ret_reg;
        cmd        = CMD_NONE;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd        = CMD_LOAD;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                case (flags.op)
                    OP_ALLOC: state_next = S_ALLOC;
                    OP_ARRAY: state_next = S_MUL;
                    OP_FREE:
                    begin
                        if (flags.present)
                        begin
                            state_next = S_AF_RD;
                        end
                        else
                        begin
                            cmd        = CMD_ST_NULL;
                            state_next = S_FINISH;
                        end
                    end
                    default: state_next = S_FINISH;
                endcase
            end
            S_MUL:
            begin
                cmd        = CMD_MUL;
                state_next = S_MULCHK;
            end
            S_MULCHK:
            begin
                if (flags.bad_array)
                begin
                    cmd        = CMD_FAIL_OOM;
                    state_next = S_FINISH;
                end
                else
                begin
                    state_next = S_ALLOC;
                end
            end
            S_ALLOC:
            begin
                if (flags.act_full)
                begin
                    cmd        = CMD_FAIL_FULL;
                    state_next = S_FINISH;
                end
                else
                begin
                    cmd        = CMD_FOOT;
                    state_next = S_BUMPCHK;
                end
            end
            S_BUMPCHK:
            begin
                if (flags.size_big)
                begin
                    cmd        = CMD_FAIL_OOM;
                    state_next = S_FINISH;
                end
                else if (flags.bump_fit)
                begin
                    cmd        = CMD_BUMP;
                    state_next = S_COMMIT;
                end
                else
                begin
                    state_next = S_FS_RD;
                end
            end
            S_FS_RD:
            begin
                if (!flags.i_lt_fcnt)
                begin
                    cmd        = CMD_FAIL_OOM;
                    state_next = S_FINISH;
                end
                else
                begin
                    cmd        = CMD_FRD_I;
                    state_next = S_FS_CHK;
                end
            end
            S_FS_CHK:
            begin
                if (flags.hit_len && flags.len_eq)
                begin
                    cmd        = CMD_TAKE_EXACT;
                    ret_next   = S_COMMIT;
                    state_next = S_RM_RD;
                end
                else if (flags.hit_len)
                begin
                    cmd        = CMD_TAKE_SPLIT;
                    state_next = S_COMMIT;
                end
                else
                begin
                    cmd        = CMD_INC;
                    state_next = S_FS_RD;
                end
            end
            // close the gap at the index counter, then return
            S_RM_RD:
            begin
                if (flags.i1_lt_fcnt)
                begin
                    cmd        = CMD_FRD_I1;
                    state_next = S_RM_WR;
                end
                else
                begin
                    cmd        = CMD_FDEC;
                    state_next = ret_reg;
                end
            end
            S_RM_WR:
            begin
                cmd        = CMD_FWR_I_RD;
                state_next = S_RM_RD;
            end
            S_COMMIT:
            begin
                cmd        = CMD_COMMIT;
                state_next = S_FINISH;
            end
            S_FINISH:
            begin
                if (flags.out_free)
                begin
                    cmd        = CMD_OUT;
                    state_next = S_IDLE;
                end
            end
            S_AF_RD:
            begin
                if (!flags.i_lt_acnt)
                begin
                    cmd        = CMD_I0;
                    state_next = S_RG_RD;
                end
                else
                begin
                    cmd        = CMD_ARD_I;
                    state_next = S_AF_CHK;
                end
            end
            S_AF_CHK:
            begin
                if (flags.hit_act)
                begin
                    cmd        = CMD_KEEP_K;
                    state_next = S_FF_FOOT;
                end
                else
                begin
                    cmd        = CMD_INC;
                    state_next = S_AF_RD;
                end
            end
            S_FF_FOOT:
            begin
                cmd        = CMD_FOOT;
                state_next = S_FF_CLIP;
            end
            S_FF_CLIP:
            begin
                cmd        = CMD_CLIP;
                state_next = S_FP_RD;
            end
            S_FP_RD:
            begin
                if (!flags.i_lt_fcnt)
                begin
                    cmd        = CMD_P_END;
                    state_next = S_FP_DEC;
                end
                else
                begin
                    cmd        = CMD_FRD_I;
                    state_next = S_FP_CHK;
                end
            end
            S_FP_CHK:
            begin
                if (flags.hit_gt)
                begin
                    cmd        = CMD_P_HIT;
                    state_next = S_FP_DEC;
                end
                else
                begin
                    cmd        = CMD_PREV;
                    state_next = S_FP_RD;
                end
            end
            S_FP_DEC:
            begin
                if (!flags.pm && !flags.nm)
                begin
                    if (flags.e_is_bump)
                    begin
                        cmd        = CMD_BUMP_DOWN_F;
                        state_next = S_FR_RD;
                    end
                    else if (flags.free_full)
                    begin
                        cmd        = CMD_ST_FULL;
                        state_next = S_FINISH;
                    end
                    else
                    begin
                        cmd        = CMD_I_FCNT;
                        state_next = S_INS_RD;
                    end
                end
                else if (flags.pm && flags.nm)
                begin
                    cmd        = CMD_MERGE_BOTH;
                    ret_next   = S_TOPCHK;
                    state_next = S_RM_RD;
                end
                else if (flags.pm)
                begin
                    cmd        = CMD_MERGE_PREV;
                    state_next = S_TOPCHK;
                end
                else
                begin
                    cmd        = CMD_MERGE_NEXT;
                    state_next = S_TOPCHK;
                end
            end
            // open a hole at the insert point, moving entries up one
            S_INS_RD:
            begin
                if (flags.i_gt_p)
                begin
                    cmd        = CMD_FRD_IM1;
                    state_next = S_INS_WR;
                end
                else
                begin
                    cmd        = CMD_INS_P;
                    state_next = S_FR_RD;
                end
            end
            S_INS_WR:
            begin
                cmd        = CMD_FWR_I_DEC;
                state_next = S_INS_RD;
            end
            S_TOPCHK:
            begin
                if (flags.top_hit)
                begin
                    cmd        = CMD_BUMP_DOWN_M;
                    ret_next   = S_FR_RD;
                    state_next = S_RM_RD;
                end
                else
                begin
                    state_next = S_FR_RD;
                end
            end
            S_FR_RD:
            begin
                cmd        = CMD_ARD_LAST;
                state_next = S_FR_WR;
            end
            S_FR_WR:
            begin
                cmd        = CMD_FREE_DONE;
                state_next = S_FINISH;
            end
            S_RG_RD:
            begin
                if (!flags.i_lt_fill)
                begin
                    cmd        = CMD_I0;
                    state_next = S_NH_CHK;
                end
                else
                begin
                    cmd        = CMD_RRD_I;
                    state_next = S_RG_CHK;
                end
            end
            S_RG_CHK:
            begin
                if (flags.hit_ring)
                begin
                    cmd        = CMD_ST_DOUBLE;
                    state_next = S_FINISH;
                end
                else
                begin
                    cmd        = CMD_INC;
                    state_next = S_RG_RD;
                end
            end
            S_NH_CHK:
            begin
                if (flags.addr_out)
                begin
                    cmd        = CMD_ST_NOTHEAP;
                    state_next = S_FINISH;
                end
                else
                begin
                    cmd        = CMD_ST_NOTALLOC;
                    state_next = S_CN_RD;
                end
            end
            S_CN_RD:
            begin
                if (!flags.i_lt_acnt)
                begin
                    state_next = S_FINISH;
                end
                else
                begin
                    cmd        = CMD_ARD_I;
                    state_next = S_CN_CHK;
                end
            end
            S_CN_CHK:
            begin
                if (flags.hit_contain)
                begin
                    cmd        = CMD_SET_OFF;
                    state_next = S_FINISH;
                end
                else
                begin
                    cmd        = CMD_INC;
                    state_next = S_CN_RD;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ret_reg   <= S_FINISH;
        end
        else
        begin
            state_reg <= state_next;
            ret_reg   <= ret_next;
        end
    end

endmodule

FILE: rtl/core/first_fit_coalescing_allocator.sv
// An allocation from the top of the arena bumps the top pointer without visiting a table;
// a free may scan the active table, the free table and then shift the free table; each
// table entry visited costs a read state and a check state on the single registered read
// port of its RAM.
// Throughput: one request at a time; the next word is taken in the cycle after the result is
// registered, and the result waits in its last state until the output register is free.
// Reset (rst_n, asynchronous, active low) clears the counts, top pointer and statistics (the
// lowest address is set to all ones); table RAMs are not cleared, only entries below their counts are ever read.
module first_fit_coalescing_allocator (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  operation,
    input  logic [23:0] request_size,
    input  logic [23:0] element_count,
    input  logic [23:0] address,
    input  logic        pointer_present,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [22:0] allocated_address,
    output logic [2:0]  status,
    output logic [22:0] offset_in_region,
    output logic [6:0]  live_allocations,
    output logic [23:0] live_bytes,
    output logic [31:0] allocations_made,
    output logic [39:0] bytes_allocated,
    output logic [31:0] failures,
    output logic [47:0] failed_bytes,
    output logic [23:0] lowest_address,
    output logic [22:0] highest_address,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import ffca_pkg::*;

    cmd_t      cmd;
    dp_flags_t flags;

    // single register: every address maps onto the guard register
    assign pready = 1'b1;

    // sequencer: walks the tables one entry at a time and issues one command a cycle
    ffca_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .flags    (flags),
        .cmd      (cmd)
    );

    // datapath: tables, top pointer, statistics and the output word register
    ffca_datapath u_dp (
        .clk               (clk),
        .rst_n             (rst_n),
        .cmd               (cmd),
        .flags             (flags),
        .operation         (operation),
        .request_size      (request_size),
        .element_count     (element_count),
        .address           (address),
        .pointer_present   (pointer_present),
        .psel              (psel),
        .penable           (penable),
        .pwrite            (pwrite),
        .pwdata            (pwdata),
        .prdata            (prdata),
        .out_valid         (out_valid),
        .out_stall         (out_stall),
        .allocated_address (allocated_address),
        .status            (status),
        .offset_in_region  (offset_in_region),
        .live_allocations  (live_allocations),
        .live_bytes        (live_bytes),
        .allocations_made  (allocations_made),
        .bytes_allocated   (bytes_allocated),
        .failures          (failures),
        .failed_bytes      (failed_bytes),
        .lowest_address    (lowest_address),
        .highest_address   (highest_address)
    );

endmodule
